FILE: src/smoothed_zscore_peak_detector_defines.svh
// Assertion macros for the smoothed z-score peak detector.
// Needs clk and rst in the scope that uses them; no other dependencies.
`ifndef SMOOTHED_ZSCORE_PEAK_DETECTOR_DEFINES_SVH
`define SMOOTHED_ZSCORE_PEAK_DETECTOR_DEFINES_SVH

// plain property, checked every edge outside reset
`define SZPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SZPD_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SZPD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/szpd_pkg.sv
// Package for the smoothed z-score peak detector: beat types, constants,
// microcode control word types and the microprogram ROM. No dependencies.
package szpd_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_BITS    = 6;
  localparam int LEN_BITS    = 7;
  localparam int SUM_BITS    = 23;
  localparam int SQ_BITS     = 38;
  localparam int THR_BITS    = 16;
  localparam int W_BITS      = 17;
  localparam int STEP_BITS   = 5;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Z_THRESHOLD      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INFLUENCE_WEIGHT = 2'd2;

  localparam logic [LEN_BITS-1:0] RST_WINDOW_LENGTH    = 7'd30;
  localparam logic [THR_BITS-1:0] RST_Z_THRESHOLD      = 16'd1280;
  localparam logic [W_BITS-1:0]   RST_INFLUENCE_WEIGHT = 17'd0;

  localparam logic [W_BITS-1:0] ONE_Q16  = 17'h10000;
  localparam int                HALF_Q16 = 32768;

  localparam logic signed [1:0] SIG_NONE = 2'sb00;
  localparam logic signed [1:0] SIG_POS  = 2'sb01;
  localparam logic signed [1:0] SIG_NEG  = 2'sb11;

  localparam logic [STEP_BITS-1:0] STEP_STATS = 5'd0;
  localparam logic [STEP_BITS-1:0] STEP_PUSH  = 5'd15;
  localparam logic [STEP_BITS-1:0] STEP_LAST  = 5'd17;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          run_start;
  } szpd_in_t;

  typedef struct packed {
    logic signed [1:0]             signal;
    logic signed [SAMPLE_BITS-1:0] filtered_sample;
    logic                          primed;
  } szpd_out_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_LX, MUL_SS, MUL_LQH, MUL_LQL, MUL_DD, MUL_TT,
    MUL_TVH, MUL_TVL, MUL_WX, MUL_WP, MUL_FF, MUL_OO
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_DIFF, OP_ACC_NEG, OP_ACC_ADD19, OP_ACC_ADD, OP_VAR_LHS, OP_THR2,
    OP_ACC_LOAD22, OP_ACC_LOAD, OP_FLAG, OP_ACC_RND, OP_BLEND, OP_SQ_ADD, OP_SQ_SUB
  } alu_op_t;

  typedef enum logic [1:0] {
    BR_NEXT, BR_NOFLAG, BR_DONE
  } br_t;

  typedef struct packed {
    mul_sel_t             mul;
    alu_op_t              op;
    br_t                  br;
    logic [STEP_BITS-1:0] target;
  } ctrl_t;

  // multiplier result is consumed one step after its operands are selected
  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_t c;
    c = '{MUL_NONE, OP_NOP, BR_NEXT, STEP_PUSH};
    unique case (step)
      5'd0:  c = '{MUL_LX,   OP_NOP,        BR_NEXT,   STEP_PUSH};
      5'd1:  c = '{MUL_SS,   OP_DIFF,       BR_NEXT,   STEP_PUSH};
      5'd2:  c = '{MUL_LQH,  OP_ACC_NEG,    BR_NEXT,   STEP_PUSH};
      5'd3:  c = '{MUL_LQL,  OP_ACC_ADD19,  BR_NEXT,   STEP_PUSH};
      5'd4:  c = '{MUL_DD,   OP_ACC_ADD,    BR_NEXT,   STEP_PUSH};
      5'd5:  c = '{MUL_TT,   OP_VAR_LHS,    BR_NEXT,   STEP_PUSH};
      5'd6:  c = '{MUL_NONE, OP_THR2,       BR_NEXT,   STEP_PUSH};
      5'd7:  c = '{MUL_TVH,  OP_NOP,        BR_NEXT,   STEP_PUSH};
      5'd8:  c = '{MUL_TVL,  OP_ACC_LOAD22, BR_NEXT,   STEP_PUSH};
      5'd9:  c = '{MUL_NONE, OP_ACC_ADD,    BR_NEXT,   STEP_PUSH};
      5'd10: c = '{MUL_NONE, OP_FLAG,       BR_NOFLAG, STEP_PUSH};
      5'd11: c = '{MUL_WX,   OP_NOP,        BR_NEXT,   STEP_PUSH};
      5'd12: c = '{MUL_WP,   OP_ACC_LOAD,   BR_NEXT,   STEP_PUSH};
      5'd13: c = '{MUL_NONE, OP_ACC_RND,    BR_NEXT,   STEP_PUSH};
      5'd14: c = '{MUL_NONE, OP_BLEND,      BR_NEXT,   STEP_PUSH};
      5'd15: c = '{MUL_FF,   OP_NOP,        BR_NEXT,   STEP_PUSH};
      5'd16: c = '{MUL_OO,   OP_SQ_ADD,     BR_NEXT,   STEP_PUSH};
      5'd17: c = '{MUL_NONE, OP_SQ_SUB,     BR_DONE,   STEP_PUSH};
      default: c = '{MUL_NONE, OP_NOP, BR_DONE, STEP_PUSH};
    endcase
    return c;
  endfunction

endpackage

FILE: src/smoothed_zscore_peak_detector.sv
// Smoothed z-score peak detector: microcoded sequencer around one shared
// 33x25 signed multiplier. Depends on szpd_pkg and the assertion defines header.
//
//   channel  signals                            beat
//   in       in_valid, in_stall, in_data        szpd_in_t  (sample, run_start)
//   out      out_valid, out_stall, out_data     szpd_out_t (signal, filtered, primed)
//   cfg      cfg_write, cfg_index, cfg_data     one register write per cycle
//
// One beat at a time: accept cycle plus 3 steps in the fill phase, 14 steps
// for an unflagged sample, 18 for a flagged one, all set by the step count
// of the microprogram on the single multiplier.
// Reset loads the register defaults and empties the window; the ring RAM is not cleared.
// The last step waits while the output register holds an untaken beat.
module smoothed_zscore_peak_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  szpd_pkg::szpd_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output szpd_pkg::szpd_out_t                  out_data,
  input  logic                                 cfg_write,
  input  logic [szpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [szpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import szpd_pkg::*;

  logic [LEN_BITS-1:0] window_length;
  logic [THR_BITS-1:0] z_threshold;
  logic [W_BITS-1:0]   influence_weight;

  logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW_MAX];
  logic [PTR_BITS-1:0]           ring_pointer;
  logic [LEN_BITS-1:0]           fill_count;
  logic signed [SUM_BITS-1:0]    window_sum;
  logic [SQ_BITS-1:0]            window_sum_squares;
  logic signed [SAMPLE_BITS-1:0] previous_filtered;

  logic                          running;
  logic [STEP_BITS-1:0]          pc;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic signed [SAMPLE_BITS-1:0] filt;
  logic signed [1:0]             sig;
  logic                          primed_r;
  logic signed [24:0]            diff;
  logic signed [57:0]            prod;
  logic signed [77:0]            acc;
  logic [43:0]                   var_r;
  logic [61:0]                   lhs;
  logic [31:0]                   thr2;

  logic [LEN_BITS-1:0]  win_len;
  logic [W_BITS-1:0]    w_sat;
  logic [W_BITS-1:0]    w_inv;
  ctrl_t                ctrl;
  logic                 in_acc;
  logic                 step_go;
  logic                 flag;
  logic signed [32:0]   mul_a;
  logic signed [24:0]   mul_b;
  logic [PTR_BITS-1:0]  ptr_base;
  logic [PTR_BITS-1:0]  ptr_eff;
  logic [LEN_BITS-1:0]  fill_eff;
  logic                 primed_eff;
  logic [LEN_BITS-1:0]  ptr_inc;
  logic                 out_valid_next;

  always_comb begin
    if (window_length == '0) begin
      win_len = LEN_BITS'(1);
    end else if (window_length > LEN_BITS'(WINDOW_MAX)) begin
      win_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      win_len = window_length;
    end
    w_sat = (influence_weight > ONE_Q16) ? ONE_Q16 : influence_weight;
    w_inv = ONE_Q16 - w_sat;
  end

  assign ctrl     = ucode(pc);
  assign in_stall = running;
  assign in_acc   = in_valid && !running;
  assign step_go  = running && !(ctrl.br == BR_DONE && out_valid && out_stall);
  assign flag     = $signed({16'd0, lhs}) > acc;

  always_comb begin
    ptr_base   = in_data.run_start ? '0 : ring_pointer;
    ptr_eff    = ({1'b0, ptr_base} >= win_len) ? '0 : ptr_base;
    fill_eff   = in_data.run_start ? '0 : fill_count;
    primed_eff = fill_eff >= win_len;
    ptr_inc    = {1'b0, ring_pointer} + LEN_BITS'(1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_LX: begin
        mul_a = 33'(win_len);
        mul_b = 25'(x_r);
      end
      MUL_SS: begin
        mul_a = 33'(window_sum);
        mul_b = 25'(window_sum);
      end
      MUL_LQH: begin
        mul_a = 33'(win_len);
        mul_b = 25'(window_sum_squares[37:19]);
      end
      MUL_LQL: begin
        mul_a = 33'(win_len);
        mul_b = 25'(window_sum_squares[18:0]);
      end
      MUL_DD: begin
        mul_a = 33'(diff);
        mul_b = diff;
      end
      MUL_TT: begin
        mul_a = 33'(z_threshold);
        mul_b = 25'(z_threshold);
      end
      MUL_TVH: begin
        mul_a = 33'(thr2);
        mul_b = 25'(var_r[43:22]);
      end
      MUL_TVL: begin
        mul_a = 33'(thr2);
        mul_b = 25'(var_r[21:0]);
      end
      MUL_WX: begin
        mul_a = 33'(w_sat);
        mul_b = 25'(x_r);
      end
      MUL_WP: begin
        mul_a = 33'(w_inv);
        mul_b = 25'(previous_filtered);
      end
      MUL_FF: begin
        mul_a = 33'(filt);
        mul_b = 25'(filt);
      end
      MUL_OO: begin
        mul_a = 33'(old_r);
        mul_b = 25'(old_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= RST_WINDOW_LENGTH;
      z_threshold      <= RST_Z_THRESHOLD;
      influence_weight <= RST_INFLUENCE_WEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:    window_length    <= cfg_data[LEN_BITS-1:0];
        REG_Z_THRESHOLD:      z_threshold      <= cfg_data[THR_BITS-1:0];
        REG_INFLUENCE_WEIGHT: influence_weight <= cfg_data[W_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ring RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (step_go && ctrl.op == OP_SQ_ADD) begin
      window_ring[ring_pointer] <= filt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      old_r <= window_ring[ptr_eff];
    end
  end

  assign out_valid_next = (step_go && ctrl.br == BR_DONE) ? 1'b1 :
                          (out_valid && !out_stall) ? 1'b0 : out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      running            <= 1'b0;
      pc                 <= STEP_STATS;
      out_valid          <= 1'b0;
      ring_pointer       <= '0;
      fill_count         <= '0;
      window_sum         <= '0;
      window_sum_squares <= '0;
      previous_filtered  <= '0;
    end else begin
      out_valid <= out_valid_next;
      if (in_acc) begin
        running      <= 1'b1;
        pc           <= primed_eff ? STEP_STATS : STEP_PUSH;
        ring_pointer <= ptr_eff;
        fill_count   <= primed_eff ? fill_eff : fill_eff + LEN_BITS'(1);
        if (in_data.run_start) begin
          window_sum         <= '0;
          window_sum_squares <= '0;
        end
      end else if (step_go) begin
        unique case (ctrl.br)
          BR_NEXT:   pc <= pc + STEP_BITS'(1);
          BR_NOFLAG: pc <= flag ? pc + STEP_BITS'(1) : ctrl.target;
          BR_DONE:   running <= 1'b0;
          default:   pc <= pc;
        endcase
        if (ctrl.op == OP_SQ_ADD) begin
          window_sum_squares <= window_sum_squares + prod[SQ_BITS-1:0];
          window_sum <= window_sum + SUM_BITS'(filt) -
                        (primed_r ? SUM_BITS'(old_r) : SUM_BITS'(0));
        end
        if (ctrl.op == OP_SQ_SUB && primed_r) begin
          window_sum_squares <= window_sum_squares - prod[SQ_BITS-1:0];
        end
        if (ctrl.br == BR_DONE) begin
          previous_filtered <= filt;
          ring_pointer      <= (ptr_inc >= win_len) ? '0 : ptr_inc[PTR_BITS-1:0];
        end
      end
    end
  end

  // datapath payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r      <= in_data.sample;
      filt     <= in_data.sample;
      sig      <= SIG_NONE;
      primed_r <= primed_eff;
    end else if (step_go) begin
      prod <= mul_a * mul_b;
      unique case (ctrl.op)
        OP_DIFF:       diff <= 25'(prod) - 25'(window_sum);
        OP_ACC_NEG:    acc <= -78'(prod);
        OP_ACC_ADD19:  acc <= acc + (78'(prod) << 19);
        OP_ACC_ADD:    acc <= acc + 78'(prod);
        OP_VAR_LHS: begin
          var_r <= acc[77] ? '0 : acc[43:0];
          lhs   <= {prod[45:0], 16'd0};
        end
        OP_THR2:       thr2 <= prod[31:0];
        OP_ACC_LOAD22: acc <= 78'(prod) << 22;
        OP_ACC_LOAD:   acc <= 78'(prod);
        OP_FLAG: begin
          if (flag) begin
            sig <= diff[24] ? SIG_NEG : SIG_POS;
          end else begin
            sig  <= SIG_NONE;
            filt <= x_r;
          end
        end
        OP_ACC_RND:    acc <= acc + 78'(prod) + 78'(HALF_Q16);
        OP_BLEND:      filt <= acc[31:16];
        default: ;
      endcase
      if (ctrl.br == BR_DONE) begin
        out_data.signal          <= sig;
        out_data.filtered_sample <= filt;
        out_data.primed          <= primed_r;
      end
    end
  end

`include "smoothed_zscore_peak_detector_defines.svh"

  `SZPD_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, running && (pc == STEP_STATS || pc == STEP_PUSH), "accepted beat did not start the sequencer")
  `SZPD_ASSERT_IMPLY(a_out_from_done, $rose(out_valid), $past(running) && $past(pc) == STEP_LAST, "output beat without a finished program")
  `SZPD_ASSERT(a_fill_bound, fill_count <= LEN_BITS'(WINDOW_MAX), "fill count beyond window size")
  `SZPD_ASSERT_IMPLY(a_signal_code, out_valid, out_data.signal != 2'b10, "invalid signal code")

endmodule
